FILE: hw/rtl/reservation_station_scheduler_macros.svh
// Assertion macros for the reservation station scheduler.
// Used by reservation_station_scheduler.sv in hw/rtl; expects clk_i and rst_ni in scope.
`ifndef RESERVATION_STATION_SCHEDULER_MACROS_SVH
`define RESERVATION_STATION_SCHEDULER_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define RSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true outside reset
`define RSS_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

FILE: hw/rtl/rss_pkg.sv
// Package for the reservation station scheduler: codes, widths and the
// structs passed between the top level and the station slices. No dependencies.
package rss_pkg;

  localparam int KindW  = 3;
  localparam int RegW   = 4;
  localparam int LatW   = 7;
  localparam int CntW   = 6;
  localparam int MaskW  = 8;
  localparam int TickW  = 32;
  localparam int StNumW = 3;
  localparam int MaxRegs = 16;

  localparam logic [LatW-1:0] LatMin = 7'd2;
  localparam logic [LatW-1:0] LatMax = 7'd64;

  typedef enum logic [KindW-1:0] {
    KIND_NONE = 3'd0,
    KIND_LOAD = 3'd1,
    KIND_ADD  = 3'd2,
    KIND_SUB  = 3'd3,
    KIND_MUL  = 3'd4,
    KIND_DIV  = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    CFG_LOAD_LAT   = 2'd0,
    CFG_ADDSUB_LAT = 2'd1,
    CFG_MUL_LAT    = 2'd2,
    CFG_DIV_LAT    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_FREE,
    ST_WAIT,
    ST_RUN,
    ST_DONE
  } phase_e;

  typedef struct packed {
    logic            en;
    logic [CntW-1:0] cnt_init;
  } st_issue_t;

  typedef struct packed {
    logic free;
    logic start;
    logic finish;
    logic bcast;
  } st_stat_t;

endpackage

FILE: hw/rtl/rss_station.sv
// One reservation station: operand wait tags, execution countdown and phase.
// Depends on rss_pkg.
module rss_station #(
  parameter int NumSt = 8,
  parameter int TagW  = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  rss_pkg::st_issue_t   issue_i,
  input  logic [TagW-1:0]      tag_a_i,
  input  logic [TagW-1:0]      tag_b_i,
  input  logic [NumSt-1:0]     bcast_i,
  output rss_pkg::st_stat_t    stat_o
);

  localparam logic [TagW-1:0] NoTag = TagW'(NumSt);
  localparam int PadW = (2 ** TagW) - NumSt;

  rss_pkg::phase_e phase_q, phase_d;
  logic [rss_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [TagW-1:0] tag_a_q, tag_a_d;
  logic [TagW-1:0] tag_b_q, tag_b_d;
  logic [(2 ** TagW)-1:0] bcast_pad;

  assign bcast_pad = {{PadW{1'b0}}, bcast_i};

  always_comb begin
    logic [TagW-1:0] ta;
    logic [TagW-1:0] tb;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    ta      = tag_a_q;
    tb      = tag_b_q;
    case (phase_q)
      rss_pkg::ST_FREE: begin
        if (issue_i.en) begin
          phase_d = rss_pkg::ST_WAIT;
          cnt_d   = issue_i.cnt_init;
          ta      = tag_a_i;
          tb      = tag_b_i;
        end
      end
      rss_pkg::ST_WAIT: begin
        if (tag_a_q == NoTag && tag_b_q == NoTag) begin
          phase_d = rss_pkg::ST_RUN;
        end
      end
      rss_pkg::ST_RUN: begin
        cnt_d = cnt_q - rss_pkg::CntW'(1);
        if (cnt_q == rss_pkg::CntW'(1)) begin
          phase_d = rss_pkg::ST_DONE;
        end
      end
      rss_pkg::ST_DONE: begin
        phase_d = rss_pkg::ST_FREE;
      end
      default: begin
        phase_d = rss_pkg::ST_FREE;
      end
    endcase
    // result bus snoop
    tag_a_d = bcast_pad[ta] ? NoTag : ta;
    tag_b_d = bcast_pad[tb] ? NoTag : tb;
  end

  always_comb begin
    stat_o.free   = (phase_q == rss_pkg::ST_FREE);
    stat_o.start  = (phase_q == rss_pkg::ST_WAIT) && (tag_a_q == NoTag) && (tag_b_q == NoTag);
    stat_o.finish = (phase_q == rss_pkg::ST_RUN) && (cnt_q == rss_pkg::CntW'(1));
    stat_o.bcast  = (phase_q == rss_pkg::ST_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rss_pkg::ST_FREE;
    end else if (en_i) begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cnt_q   <= cnt_d;
      tag_a_q <= tag_a_d;
      tag_b_q <= tag_b_d;
    end
  end

endmodule

FILE: hw/rtl/reservation_station_scheduler.sv
// Reservation station scheduler: Tomasulo issue, wakeup and result broadcast
// timing, one machine cycle per input transaction. Depends on rss_pkg,
// rss_station and reservation_station_scheduler_macros.svh.
//
// Usage:
//   s_axis: one transaction per machine cycle; tdata carries kind, dest_reg,
//     src_reg_a, src_reg_b. A kind of none still advances the machine.
//   m_axis: one result transaction per input: issued flag, station taken,
//     start/finish/broadcast masks of that cycle and the cycle count.
//   cfg: latency registers (load, add/sub, mul, div), written by index; always
//     ready. Values below 2 act as 2, above 64 as 64.
// Pipeline: input register, then the station update and result register in
//   one pass.
// Throughput: one transaction per clock unless m_axis stalls; all stations, the
//   register status table and result bus snoop update together in one pass.
// Reset: all stations free, all register tags clear, cycle count zero,
//   latencies 2, 2, 10, 40.
// Stall: when m_axis is not taken the result holds, the input register fills,
//   and s_axis_tready_o drops until the result is taken.
`include "reservation_station_scheduler_macros.svh"

module reservation_station_scheduler #(
  parameter int NUM_REGISTERS   = 16,
  parameter int LOAD_STATIONS   = 3,
  parameter int ADD_STATIONS    = 3,
  parameter int MULDIV_STATIONS = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [2:0] kind, [6:3] dest_reg, [10:7] src_reg_a, [14:11] src_reg_b, [15] zero
  input  logic [15:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] issued, [3:1] issued_station, [11:4] start_mask, [19:12] finish_mask,
  // [27:20] broadcast_mask, [59:28] tick_number, [63:60] zero
  output logic [63:0] m_axis_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i
);

  localparam int NumSt   = LOAD_STATIONS + ADD_STATIONS + MULDIV_STATIONS;
  localparam int TagW    = $clog2(NumSt + 1);
  localparam int PadW    = (2 ** TagW) - NumSt;
  localparam int NumRegs = (NUM_REGISTERS < rss_pkg::MaxRegs) ? NUM_REGISTERS
                                                               : rss_pkg::MaxRegs;
  localparam int RegIdxW = $clog2(NumRegs);
  localparam int AddLo   = LOAD_STATIONS;
  localparam int MdLo    = LOAD_STATIONS + ADD_STATIONS;
  localparam logic [TagW-1:0] NoTag = TagW'(NumSt);

  // configuration
  logic [rss_pkg::LatW-1:0] lat_load_q, lat_addsub_q, lat_mul_q, lat_div_q;

  // input register
  logic                      in_valid_q;
  logic [rss_pkg::KindW-1:0] in_kind_q;
  logic [rss_pkg::RegW-1:0]  in_dest_q, in_sa_q, in_sb_q;

  // result register
  logic                       m_valid_q;
  logic                       out_issued_q;
  logic [rss_pkg::StNumW-1:0] out_station_q;
  logic [rss_pkg::MaskW-1:0]  out_start_q, out_finish_q, out_bcast_q;
  logic [rss_pkg::TickW-1:0]  tick_q;

  logic advance;
  logic issue_fire;
  logic found;
  logic [NumSt-1:0] sel_oh;
  logic [TagW-1:0]  sel_tag;
  logic [rss_pkg::StNumW-1:0] sel_num;
  logic [rss_pkg::LatW-1:0] lat_raw, lat_clamp;
  logic is_load;
  logic [TagW-1:0] src_tag_a, src_tag_b;
  logic [rss_pkg::MaskW-1:0] start_m, finish_m, bcast_m;

  rss_pkg::st_stat_t  stat   [NumSt];
  rss_pkg::st_issue_t issue  [NumSt];
  logic [NumSt-1:0]   bcast_vec;
  logic [(2 ** TagW)-1:0] bcast_pad;

  logic [TagW-1:0] regtag_q [NumRegs];
  logic [TagW-1:0] regtag_d [NumRegs];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_load_q   <= 7'd2;
      lat_addsub_q <= 7'd2;
      lat_mul_q    <= 7'd10;
      lat_div_q    <= 7'd40;
    end else if (cfg_valid_i) begin
      case (rss_pkg::cfg_idx_e'(cfg_index_i))
        rss_pkg::CFG_LOAD_LAT:   lat_load_q   <= cfg_data_i;
        rss_pkg::CFG_ADDSUB_LAT: lat_addsub_q <= cfg_data_i;
        rss_pkg::CFG_MUL_LAT:    lat_mul_q    <= cfg_data_i;
        rss_pkg::CFG_DIV_LAT:    lat_div_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // handshake
  assign advance         = in_valid_q && (!m_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign m_axis_tvalid_o = m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
      tick_q     <= '0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        m_valid_q <= 1'b1;
        tick_q    <= tick_q + rss_pkg::TickW'(1);
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_kind_q <= s_axis_tdata_i[2:0];
      in_dest_q <= s_axis_tdata_i[6:3];
      in_sa_q   <= s_axis_tdata_i[10:7];
      in_sb_q   <= s_axis_tdata_i[14:11];
    end
    if (advance) begin
      out_issued_q  <= found;
      out_station_q <= found ? sel_num : '0;
      out_start_q   <= start_m;
      out_finish_q  <= finish_m;
      out_bcast_q   <= bcast_m;
    end
  end

  // station group and latency select
  always_comb begin
    int lo;
    int hi;
    logic kind_ok;
    lo      = 0;
    hi      = 0;
    kind_ok = 1'b1;
    is_load = 1'b0;
    lat_raw = lat_load_q;
    case (rss_pkg::kind_e'(in_kind_q))
      rss_pkg::KIND_LOAD: begin
        lo      = 0;
        hi      = LOAD_STATIONS;
        is_load = 1'b1;
        lat_raw = lat_load_q;
      end
      rss_pkg::KIND_ADD, rss_pkg::KIND_SUB: begin
        lo      = AddLo;
        hi      = MdLo;
        lat_raw = lat_addsub_q;
      end
      rss_pkg::KIND_MUL: begin
        lo      = MdLo;
        hi      = NumSt;
        lat_raw = lat_mul_q;
      end
      rss_pkg::KIND_DIV: begin
        lo      = MdLo;
        hi      = NumSt;
        lat_raw = lat_div_q;
      end
      default: begin
        kind_ok = 1'b0;
      end
    endcase
    found   = 1'b0;
    sel_oh  = '0;
    sel_tag = NoTag;
    sel_num = '0;
    for (int j = 0; j < NumSt; j++) begin
      if (kind_ok && !found && j >= lo && j < hi && stat[j].free) begin
        found     = 1'b1;
        sel_oh[j] = 1'b1;
        sel_tag   = TagW'(j);
        sel_num   = rss_pkg::StNumW'(j);
      end
    end
  end

  assign lat_clamp  = (lat_raw < rss_pkg::LatMin) ? rss_pkg::LatMin :
                      (lat_raw > rss_pkg::LatMax) ? rss_pkg::LatMax : lat_raw;
  assign issue_fire = advance && found;

  // register status read for the sources
  assign src_tag_a = (is_load || (5'(in_sa_q) >= 5'(NumRegs))) ? NoTag
                   : regtag_q[in_sa_q[RegIdxW-1:0]];
  assign src_tag_b = (is_load || (5'(in_sb_q) >= 5'(NumRegs))) ? NoTag
                   : regtag_q[in_sb_q[RegIdxW-1:0]];

  for (genvar g = 0; g < NumSt; g++) begin : g_st
    assign issue[g].en       = issue_fire && sel_oh[g];
    assign issue[g].cnt_init = rss_pkg::CntW'(lat_clamp - rss_pkg::LatW'(1));
    assign bcast_vec[g]      = stat[g].bcast;

    rss_station #(
      .NumSt (NumSt),
      .TagW  (TagW)
    ) u_station (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .issue_i (issue[g]),
      .tag_a_i (src_tag_a),
      .tag_b_i (src_tag_b),
      .bcast_i (bcast_vec),
      .stat_o  (stat[g])
    );
  end

  assign bcast_pad = {{PadW{1'b0}}, bcast_vec};

  always_comb begin
    start_m  = '0;
    finish_m = '0;
    bcast_m  = '0;
    for (int j = 0; j < rss_pkg::MaskW; j++) begin
      if (j < NumSt) begin
        start_m[j]  = stat[j].start;
        finish_m[j] = stat[j].finish;
        bcast_m[j]  = stat[j].bcast;
      end
    end
  end

  // register status table: rename wins over the broadcast clear
  always_comb begin
    for (int r = 0; r < NumRegs; r++) begin
      regtag_d[r] = bcast_pad[regtag_q[r]] ? NoTag : regtag_q[r];
      if (issue_fire && in_dest_q == rss_pkg::RegW'(r)) begin
        regtag_d[r] = sel_tag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumRegs; r++) begin
        regtag_q[r] <= NoTag;
      end
    end else if (advance) begin
      for (int r = 0; r < NumRegs; r++) begin
        regtag_q[r] <= regtag_d[r];
      end
    end
  end

  assign m_axis_tdata_o = {4'b0000, tick_q, out_bcast_q, out_finish_q, out_start_q,
                           out_station_q, out_issued_q};

  `RSS_ASSERT_NEVER(a_masks_disjoint, m_valid_q && (((out_start_q & out_finish_q) != '0) || ((out_finish_q & out_bcast_q) != '0)), "station both started and finished, or finished and broadcast")
  `RSS_ASSERT(a_fresh_idle, (NumSt <= rss_pkg::MaskW) && m_valid_q && out_issued_q |-> !out_start_q[out_station_q] && !out_finish_q[out_station_q] && !out_bcast_q[out_station_q], "newly issued station acted in its issue cycle")
  `RSS_ASSERT(a_tick_step, advance |=> tick_q == $past(tick_q) + rss_pkg::TickW'(1), "cycle count did not step with the transaction")

endmodule

FILE: sim/testbench.sv
// Self-checking bench for reservation_station_scheduler: drives instruction ticks on the
// input stream, predicts Tomasulo issue/start/finish/broadcast masks cycle by cycle and
// compares every result transaction. Depends on rss_pkg and the scheduler RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ST  = 8;
  localparam int LOAD_ST = 3;
  localparam int ADD_ST  = 3;
  localparam int NUM_REG = 16;
  localparam int NO_TAG  = NUM_ST;
  localparam logic [rss_pkg::KindW-1:0] KIND_UNUSED_6 = 3'd6;
  localparam logic [rss_pkg::KindW-1:0] KIND_UNUSED_7 = 3'd7;

  // issued sits in the low bit so the struct maps straight onto m_axis tdata
  typedef struct packed {
    logic [rss_pkg::TickW-1:0]  tick;
    logic [rss_pkg::MaskW-1:0]  bcast_m;
    logic [rss_pkg::MaskW-1:0]  finish_m;
    logic [rss_pkg::MaskW-1:0]  start_m;
    logic [rss_pkg::StNumW-1:0] station;
    logic                       issued;
  } tick_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;

  // machine state as predicted
  logic [6:0]   lat_reg [4];
  logic [31:0]  tick_cnt;
  bit           st_busy [NUM_ST];
  int           st_count [NUM_ST];
  int           st_tag_a [NUM_ST];
  int           st_tag_b [NUM_ST];
  int           reg_tag [NUM_REG];

  tick_result_t expected_ticks [$];
  int unsigned  mismatches = 0;
  bit           src_gaps_on = 1'b1;

  event         hold_go;
  int unsigned  hold_len = 0;
  logic         hold_active = 1'b0;

  always #1 clk = ~clk;

  reservation_station_scheduler dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  function automatic tick_result_t advance_machine(logic [2:0] kind, logic [3:0] dst,
                                                   logic [3:0] sa, logic [3:0] sb);
    tick_result_t res;
    bit fresh [NUM_ST];
    bit done_now [NUM_ST];
    int lo;
    int hi;
    int lat;
    res = '0;
    lo = 0;
    hi = 0;
    lat = 2;
    tick_cnt = tick_cnt + 1;
    foreach (fresh[j]) begin
      fresh[j] = 1'b0;
      done_now[j] = 1'b0;
    end
    case (kind)
      rss_pkg::KIND_LOAD: begin
        hi = LOAD_ST;
        lat = int'(lat_reg[rss_pkg::CFG_LOAD_LAT]);
      end
      rss_pkg::KIND_ADD, rss_pkg::KIND_SUB: begin
        lo = LOAD_ST;
        hi = LOAD_ST + ADD_ST;
        lat = int'(lat_reg[rss_pkg::CFG_ADDSUB_LAT]);
      end
      rss_pkg::KIND_MUL: begin
        lo = LOAD_ST + ADD_ST;
        hi = NUM_ST;
        lat = int'(lat_reg[rss_pkg::CFG_MUL_LAT]);
      end
      rss_pkg::KIND_DIV: begin
        lo = LOAD_ST + ADD_ST;
        hi = NUM_ST;
        lat = int'(lat_reg[rss_pkg::CFG_DIV_LAT]);
      end
      default: ;
    endcase
    lat = (lat < 2) ? 2 : (lat > 64) ? 64 : lat;

    // issue: source tags are read before the destination is renamed
    for (int j = lo; j < hi; j++) begin
      if (!st_busy[j]) begin
        st_busy[j] = 1'b1;
        st_count[j] = -(lat - 1);
        st_tag_a[j] = (kind == rss_pkg::KIND_LOAD) ? NO_TAG : reg_tag[sa];
        st_tag_b[j] = (kind == rss_pkg::KIND_LOAD) ? NO_TAG : reg_tag[sb];
        reg_tag[dst] = j;
        fresh[j] = 1'b1;
        res.issued = 1'b1;
        res.station = rss_pkg::StNumW'(j);
        break;
      end
    end

    for (int j = 0; j < NUM_ST; j++) begin
      if (st_busy[j] && !fresh[j]) begin
        if (st_count[j] > 0) begin
          st_count[j]--;
          if (st_count[j] == 0) begin
            done_now[j] = 1'b1;
            res.finish_m[j] = 1'b1;
          end
        end else if (st_count[j] < 0 && st_tag_a[j] == NO_TAG && st_tag_b[j] == NO_TAG) begin
          st_count[j] = -st_count[j];
          res.start_m[j] = 1'b1;
        end
      end
    end

    // broadcast stations that finished on an earlier tick
    for (int j = 0; j < NUM_ST; j++) begin
      if (st_busy[j] && !done_now[j] && st_count[j] == 0) begin
        foreach (reg_tag[r]) begin
          if (reg_tag[r] == j) reg_tag[r] = NO_TAG;
        end
        foreach (st_tag_a[k]) begin
          if (st_tag_a[k] == j) st_tag_a[k] = NO_TAG;
          if (st_tag_b[k] == j) st_tag_b[k] = NO_TAG;
        end
        st_busy[j] = 1'b0;
        st_count[j] = -1;
        st_tag_a[j] = NO_TAG;
        st_tag_b[j] = NO_TAG;
        res.bcast_m[j] = 1'b1;
      end
    end
    res.tick = tick_cnt;
    return res;
  endfunction

  task automatic send_instr(input logic [2:0] kind, input logic [3:0] dst,
                            input logic [3:0] sa, input logic [3:0] sb, output bit took);
    int unsigned gap;
    tick_result_t res;
    gap = src_gaps_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, sb, sa, dst, kind};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    res = advance_machine(kind, dst, sa, sb);
    expected_ticks.push_back(res);
    took = res.issued;
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
  endtask

  task automatic program_latencies(logic [6:0] ld, logic [6:0] as, logic [6:0] ml,
                                   logic [6:0] dv);
    logic [6:0] vals [4];
    rss_pkg::cfg_idx_e idx;
    vals = '{ld, as, ml, dv};
    idx = rss_pkg::CFG_LOAD_LAT;
    do begin
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= vals[idx];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      lat_reg[idx] = vals[idx];
      idx = idx.next();
    end while (idx != rss_pkg::CFG_LOAD_LAT);
    cfg_valid <= 1'b0;
  endtask

  task automatic compare_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // random instruction stream; a refused instruction is mostly re-offered
  task automatic test_random_stream(int unsigned n_instr);
    logic [2:0] kind;
    logic [3:0] dst;
    logic [3:0] sa;
    logic [3:0] sb;
    bit pending;
    bit took;
    int unsigned sent;
    int unsigned span;
    pending = 1'b0;
    sent = 0;
    while (sent < n_instr) begin
      if ($urandom_range(0, 39) == 0) src_gaps_on = !src_gaps_on;
      if (!pending) begin
        span = ($urandom_range(0, 3) == 0) ? 15 : 5;
        case ($urandom_range(0, 19))
          0, 1: kind = rss_pkg::KIND_NONE;
          2: kind = $urandom_range(0, 1) ? KIND_UNUSED_6 : KIND_UNUSED_7;
          default: kind = 3'($urandom_range(rss_pkg::KIND_LOAD, rss_pkg::KIND_DIV));
        endcase
        dst = 4'($urandom_range(0, span));
        sa = 4'($urandom_range(0, span));
        sb = 4'($urandom_range(0, span));
      end
      send_instr(kind, dst, sa, sb, took);
      if (kind >= rss_pkg::KIND_LOAD && kind <= rss_pkg::KIND_DIV) sent++;
      pending = !took && kind >= rss_pkg::KIND_LOAD && kind <= rss_pkg::KIND_DIV &&
                $urandom_range(0, 4) != 0;
    end
    wait_results_drained();
  endtask

  task automatic test_issue_and_dependencies();
    bit took;
    send_instr(rss_pkg::KIND_LOAD, 4'd1, 4'd15, 4'd15, took);
    send_instr(rss_pkg::KIND_ADD, 4'd2, 4'd1, 4'd1, took);
    send_instr(rss_pkg::KIND_SUB, 4'd15, 4'd2, 4'd0, took);
    send_instr(rss_pkg::KIND_MUL, 4'd3, 4'd15, 4'd2, took);
    send_instr(rss_pkg::KIND_DIV, 4'd0, 4'd3, 4'd1, took);
    send_instr(rss_pkg::KIND_NONE, 4'd15, 4'd15, 4'd15, took);
    send_instr(KIND_UNUSED_6, 4'd15, 4'd15, 4'd15, took);
    send_instr(KIND_UNUSED_7, 4'd15, 4'd15, 4'd15, took);
    send_instr(rss_pkg::KIND_LOAD, 4'd15, 4'd0, 4'd0, took);
    wait_results_drained();
  endtask

  task automatic test_station_exhaustion();
    bit took;
    program_latencies(7'd64, 7'd64, 7'd64, 7'd64);
    src_gaps_on = 1'b0;
    repeat (4) send_instr(rss_pkg::KIND_LOAD, 4'd8, 4'd9, 4'd10, took);
    send_instr(rss_pkg::KIND_ADD, 4'd9, 4'd8, 4'd8, took);
    send_instr(rss_pkg::KIND_SUB, 4'd10, 4'd9, 4'd8, took);
    send_instr(rss_pkg::KIND_ADD, 4'd11, 4'd10, 4'd9, took);
    send_instr(rss_pkg::KIND_SUB, 4'd12, 4'd11, 4'd10, took);
    send_instr(rss_pkg::KIND_MUL, 4'd13, 4'd12, 4'd11, took);
    send_instr(rss_pkg::KIND_DIV, 4'd14, 4'd13, 4'd12, took);
    send_instr(rss_pkg::KIND_MUL, 4'd15, 4'd14, 4'd13, took);
    wait_results_drained();
  endtask

  task automatic test_latency_clamping();
    bit took;
    program_latencies(7'd0, 7'd1, 7'd127, 7'd65);
    src_gaps_on = 1'b1;
    send_instr(rss_pkg::KIND_LOAD, 4'd4, 4'd0, 4'd0, took);
    send_instr(rss_pkg::KIND_ADD, 4'd5, 4'd4, 4'd4, took);
    send_instr(rss_pkg::KIND_MUL, 4'd6, 4'd5, 4'd4, took);
    send_instr(rss_pkg::KIND_DIV, 4'd7, 4'd6, 4'd5, took);
    wait_results_drained();
  endtask

  task automatic test_random_traffic();
    program_latencies(7'd2, 7'd2, 7'd2, 7'd2);
    test_random_stream(170);
    program_latencies(7'($urandom_range(2, 8)), 7'($urandom_range(2, 8)),
                      7'($urandom_range(2, 12)), 7'($urandom_range(2, 16)));
    test_random_stream(170);
    program_latencies(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                      7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
    test_random_stream(130);
    program_latencies(7'd64, 7'd2, 7'd2, 7'd64);
    test_random_stream(130);
  endtask

  task automatic test_result_backpressure();
    program_latencies(7'd3, 7'd2, 7'd5, 7'd9);
    src_gaps_on = 1'b0;
    hold_len = 300;
    -> hold_go;
    test_random_stream(70);
  endtask

  initial begin : long_hold
    forever begin
      @(hold_go);
      hold_active <= 1'b1;
      repeat (hold_len) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  initial begin : result_sink
    int unsigned wait_left;
    bit gaps_on;
    tick_result_t got;
    tick_result_t want;
    wait_left = 0;
    gaps_on = 1'b1;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(tick_result_t)-1:0];
        if (expected_ticks.size() == 0) begin
          $display("%0t ns: result transaction with none expected, actual 0x%0h", $time, got);
          mismatches++;
        end else begin
          want = expected_ticks.pop_front();
          compare_field("issued", want.issued, got.issued);
          compare_field("issued_station", want.station, got.station);
          compare_field("start_mask", want.start_m, got.start_m);
          compare_field("finish_mask", want.finish_m, got.finish_m);
          compare_field("broadcast_mask", want.bcast_m, got.bcast_m);
          compare_field("tick_number", want.tick, got.tick);
          compare_field("pad", 0, m_axis_tdata[63:$bits(tick_result_t)]);
        end
        if ($urandom_range(0, 39) == 0) gaps_on = !gaps_on;
        wait_left = gaps_on ? $urandom_range(0, 18) : 0;
      end
      if (hold_active || wait_left > 0) begin
        m_axis_tready <= 1'b0;
        if (!hold_active) wait_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #800_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : main
    lat_reg = '{7'd2, 7'd2, 7'd10, 7'd40};
    tick_cnt = '0;
    foreach (st_busy[j]) begin
      st_busy[j] = 1'b0;
      st_count[j] = -1;
      st_tag_a[j] = NO_TAG;
      st_tag_b[j] = NO_TAG;
    end
    foreach (reg_tag[r]) reg_tag[r] = NO_TAG;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_issue_and_dependencies();
    test_station_exhaustion();
    test_latency_clamping();
    test_random_traffic();
    test_result_backpressure();

    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_ticks.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
